// ----- sv/lcd_window_pixel_writer_unit_macros.svh -----
`ifndef LCD_WINDOW_PIXEL_WRITER_UNIT_MACROS_SVH
`define LCD_WINDOW_PIXEL_WRITER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LCDWPW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LCDWPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lcdwpw_pkg.sv -----
`default_nettype none

package lcdwpw_pkg;

    localparam int COORD_W    = 10;
    localparam int FIELD_W    = 9;
    localparam int PANEL_W    = 9;
    localparam int COLOR_W    = 16;
    localparam int ADDR_W     = 17;
    localparam int RGB_W      = 24;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int PROD_W     = 2 * COORD_W;

    typedef enum logic {
        OP_SET_WINDOW = 1'b0,
        OP_PIXEL      = 1'b1
    } t_opcode;

    typedef enum logic {
        REG_PANEL_WIDTH  = 1'b0,
        REG_PANEL_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_opcode              opcode;
        logic [FIELD_W-1:0]   win_x;
        logic [FIELD_W-1:0]   win_y;
        logic [FIELD_W-1:0]   win_w;
        logic [FIELD_W-1:0]   win_h;
        logic [COLOR_W-1:0]   pixel_color;
    } t_cmd;

    typedef struct packed {
        t_coord col;
        t_coord row;
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
        logic   empty;
    } t_win_state;

    typedef struct packed {
        logic              write_valid;
        logic [ADDR_W-1:0] write_address;
        logic [RGB_W-1:0]  write_rgb;
    } t_wr_item;

    function automatic logic [RGB_W-1:0] widen565(input logic [COLOR_W-1:0] c);
        return {c[15:11], 3'b000, c[10:5], 2'b00, c[4:0], 3'b000};
    endfunction

endpackage

`default_nettype wire

// ----- sv/lcdwpw_in_if.sv -----
`default_nettype none

interface lcdwpw_in_if import lcdwpw_pkg::*;;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [FIELD_W-1:0] win_x;
    logic [FIELD_W-1:0] win_y;
    logic [FIELD_W-1:0] win_w;
    logic [FIELD_W-1:0] win_h;
    logic [COLOR_W-1:0] pixel_color;

    modport source (
        output valid, opcode, win_x, win_y, win_w, win_h, pixel_color,
        input  ready
    );

    modport sink (
        input  valid, opcode, win_x, win_y, win_w, win_h, pixel_color,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/lcdwpw_out_if.sv -----
`default_nettype none

interface lcdwpw_out_if import lcdwpw_pkg::*;;
    logic              valid;
    logic              ready;
    logic              write_valid;
    logic [ADDR_W-1:0] write_address;
    logic [RGB_W-1:0]  write_rgb;

    modport source (
        output valid, write_valid, write_address, write_rgb,
        input  ready
    );

    modport sink (
        input  valid, write_valid, write_address, write_rgb,
        output ready
    );
endinterface

`default_nettype wire

// ----- sv/lcdwpw_step.sv -----
`default_nettype none

module lcdwpw_step import lcdwpw_pkg::*; #(
    parameter int MAX_SIDE = 320
) (
    input  t_cmd               i_cmd,
    input  t_win_state         i_state,
    input  logic [PANEL_W-1:0] i_panel_w,
    input  logic [PANEL_W-1:0] i_panel_h,
    output t_wr_item           o_result,
    output t_win_state         o_state
);

    localparam t_coord SIDE_MAX = t_coord'(MAX_SIDE);

    t_coord            pw;
    t_coord            ph;
    t_coord            sum_right;
    t_coord            sum_bottom;
    logic              new_empty;
    logic              in_bounds;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] addr_full;

    assign pw = (t_coord'(i_panel_w) > SIDE_MAX) ? SIDE_MAX : t_coord'(i_panel_w);
    assign ph = (t_coord'(i_panel_h) > SIDE_MAX) ? SIDE_MAX : t_coord'(i_panel_h);

    assign new_empty  = (i_cmd.win_w == '0) || (i_cmd.win_h == '0);
    assign sum_right  = t_coord'(i_cmd.win_x) + t_coord'(i_cmd.win_w) - t_coord'(1);
    assign sum_bottom = t_coord'(i_cmd.win_y) + t_coord'(i_cmd.win_h) - t_coord'(1);

    assign in_bounds = !i_state.empty
                 && (i_state.col >= i_state.left) && (i_state.col <= i_state.right)
                 && (i_state.row >= i_state.top)  && (i_state.row <= i_state.bottom)
                 && (i_state.col < pw) && (i_state.row < ph);

    assign prod      = i_state.row * pw;
    assign addr_full = prod + PROD_W'(i_state.col);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        unique case (i_cmd.opcode)
            OP_SET_WINDOW: begin
                o_state.col   = t_coord'(i_cmd.win_x);
                o_state.row   = t_coord'(i_cmd.win_y);
                o_state.left  = t_coord'(i_cmd.win_x);
                o_state.top   = t_coord'(i_cmd.win_y);
                o_state.empty = new_empty;
                if (new_empty) begin
                    o_state.right  = t_coord'(i_cmd.win_x);
                    o_state.bottom = t_coord'(i_cmd.win_y);
                end else begin
                    o_state.right  = sum_right;
                    o_state.bottom = sum_bottom;
                end
            end
            OP_PIXEL: begin
                if (in_bounds) begin
                    o_result.write_valid   = 1'b1;
                    o_result.write_address = addr_full[ADDR_W-1:0];
                    o_result.write_rgb     = widen565(i_cmd.pixel_color);
                    if (i_state.col == i_state.right) begin
                        o_state.col = i_state.left;
                        if (i_state.row == i_state.bottom) begin
                            o_state.row = i_state.top;
                        end else begin
                            o_state.row = i_state.row + t_coord'(1);
                        end
                    end else begin
                        o_state.col = i_state.col + t_coord'(1);
                    end
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/lcd_window_pixel_writer_unit.sv -----
// Frame memory pixel writer with window auto-increment. Each input item is a
// set-window command or one RGB565 pixel; each gives exactly one result item,
// which carries an RGB888 write at row*width+column when the cursor lies in
// both window and panel, and all zeros otherwise. One item is taken per clock
// while the result port is not stalled; an item is held in the input register,
// where the cursor update and the 10x10 address multiply run, and then sits in
// the result register. The cursor register closes its loop within the input
// stage. Write the panel size registers over APB only while no item is in
// flight; the panel sizes used for addressing saturate at MAX_SIDE.
`default_nettype none

`include "lcd_window_pixel_writer_unit_macros.svh"

module lcd_window_pixel_writer_unit import lcdwpw_pkg::*; #(
    parameter int MAX_SIDE = 320
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lcdwpw_in_if.sink             i_pix,
    lcdwpw_out_if.source          o_wr,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [PANEL_W-1:0] r_panel_w;
    logic [PANEL_W-1:0] r_panel_h;
    t_win_state         r_state;
    t_win_state         n_state;
    logic               r_in_valid;
    t_cmd               r_in_cmd;
    logic               r_out_valid;
    t_wr_item           r_out_item;
    t_wr_item           n_out_item;
    logic               advance;
    logic               in_take;
    logic               cfg_we;
    t_reg_idx           cfg_idx;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        unique case (cfg_idx)
            REG_PANEL_WIDTH:  prdata = APB_DATA_W'(r_panel_w);
            REG_PANEL_HEIGHT: prdata = APB_DATA_W'(r_panel_h);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_panel_w <= PANEL_W'(240);
            r_panel_h <= PANEL_W'(320);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_PANEL_WIDTH:  r_panel_w <= pwdata[PANEL_W-1:0];
                REG_PANEL_HEIGHT: r_panel_h <= pwdata[PANEL_W-1:0];
            endcase
        end
    end

    // handshake
    assign advance     = r_in_valid && (!r_out_valid || o_wr.ready);
    assign i_pix.ready = !r_in_valid || advance;
    assign in_take     = i_pix.valid && i_pix.ready;

    lcdwpw_step #(
        .MAX_SIDE (MAX_SIDE)
    ) u_step (
        .i_cmd     (r_in_cmd),
        .i_state   (r_state),
        .i_panel_w (r_panel_w),
        .i_panel_h (r_panel_h),
        .o_result  (n_out_item),
        .o_state   (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (o_wr.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd.opcode      <= t_opcode'(i_pix.opcode);
            r_in_cmd.win_x       <= i_pix.win_x;
            r_in_cmd.win_y       <= i_pix.win_y;
            r_in_cmd.win_w       <= i_pix.win_w;
            r_in_cmd.win_h       <= i_pix.win_h;
            r_in_cmd.pixel_color <= i_pix.pixel_color;
        end
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_wr.valid         = r_out_valid;
    assign o_wr.write_valid   = r_out_item.write_valid;
    assign o_wr.write_address = r_out_item.write_address;
    assign o_wr.write_rgb     = r_out_item.write_rgb;

    `LCDWPW_ASSERT_NEXT(a_set_window_cursor, i_clk, i_rst_n,
        advance && (r_in_cmd.opcode == OP_SET_WINDOW),
        (r_state.col == r_state.left) && (r_state.row == r_state.top),
        "set window did not place cursor at window corner")

    `LCDWPW_ASSERT_NEXT(a_skip_holds_cursor, i_clk, i_rst_n,
        advance && (r_in_cmd.opcode == OP_PIXEL) && !n_out_item.write_valid,
        $stable(r_state),
        "unwritten pixel moved the cursor")

    `LCDWPW_ASSERT_NEXT(a_write_moves_cursor, i_clk, i_rst_n,
        advance && n_out_item.write_valid
            && ((r_state.left != r_state.right) || (r_state.top != r_state.bottom)),
        ($past(r_state.col) != r_state.col) || ($past(r_state.row) != r_state.row),
        "written pixel left the cursor in place")

    `LCDWPW_ASSERT_NOW(a_valid_result_in_window, i_clk, i_rst_n,
        advance && n_out_item.write_valid,
        !r_state.empty && (r_in_cmd.opcode == OP_PIXEL),
        "write issued outside a pixel item or into an empty window")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench import lcdwpw_pkg::*;;

    localparam int MAX_SIDE    = 320;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 53;
    localparam int N_PLANNED   = 7;
    localparam int N_PHASES    = 10;

    localparam int PLAN_W [N_PLANNED] = '{320, 1, 320, 0, 240, 511, 1};
    localparam int PLAN_H [N_PLANNED] = '{320, 320, 1, 240, 0, 511, 1};

    typedef struct {
        t_opcode op;
        int      x;
        int      y;
        int      w;
        int      h;
        int      color;
        bit      typed;
        int      valid;
        int      addr;
        int      rgb;
    } t_probe_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    lcdwpw_in_if  pix_if ();
    lcdwpw_out_if wr_if ();

    lcd_window_pixel_writer_unit #(
        .MAX_SIDE(MAX_SIDE)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_wr    (wr_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [PANEL_W-1:0] cfg_width  = 9'd240;
    logic [PANEL_W-1:0] cfg_height = 9'd320;
    t_coord             pen_col    = '0;
    t_coord             pen_row    = '0;
    t_coord             box_left   = '0;
    t_coord             box_top    = '0;
    t_coord             box_right  = '0;
    t_coord             box_bottom = '0;
    logic               box_empty  = 1'b0;

    t_wr_item pending_writes[$];
    int       error_count = 0;
    int       cycle_count = 0;
    bit       feed_burst  = 1'b0;
    bit       drain_burst = 1'b0;

    t_probe_row probe_rows[$] = '{
        '{OP_PIXEL,      0,   0,   0,   0, 'hFFFF, 1, 1,     0, 'hF8FCF8},
        '{OP_PIXEL,      0,   0,   0,   0, 'h0000, 1, 1,     0, 'h000000},
        '{OP_SET_WINDOW, 0,   0,   2,   2, 'h0000, 1, 0,     0, 0},
        '{OP_PIXEL,      0,   0,   0,   0, 'hF800, 1, 1,     0, 'hF80000},
        '{OP_PIXEL,      0,   0,   0,   0, 'h07E0, 1, 1,     1, 'h00FC00},
        '{OP_PIXEL,      0,   0,   0,   0, 'h001F, 1, 1,   240, 'h0000F8},
        '{OP_PIXEL,      0,   0,   0,   0, 'hFFFF, 1, 1,   241, 'hF8FCF8},
        '{OP_PIXEL,      0,   0,   0,   0, 'h1234, 0, 0,     0, 0},
        '{OP_SET_WINDOW, 239, 319, 1,   1, 'h0000, 1, 0,     0, 0},
        '{OP_PIXEL,      0,   0,   0,   0, 'hFFFF, 1, 1, 76799, 'hF8FCF8},
        '{OP_PIXEL,      511, 511, 511, 511, 'h0821, 0, 0,   0, 0},
        '{OP_SET_WINDOW, 5,   5,   0,   3, 'h0000, 1, 0,     0, 0},
        '{OP_PIXEL,      0,   0,   0,   0, 'hFFFF, 1, 0,     0, 0},
        '{OP_SET_WINDOW, 5,   5,   3,   0, 'h0000, 1, 0,     0, 0},
        '{OP_PIXEL,      0,   0,   0,   0, 'hFFFF, 1, 0,     0, 0},
        '{OP_SET_WINDOW, 300, 0,   20,  2, 'h0000, 1, 0,     0, 0},
        '{OP_PIXEL,      0,   0,   0,   0, 'hFFFF, 1, 0,     0, 0},
        '{OP_SET_WINDOW, 511, 511, 511, 511, 'hFFFF, 1, 0,   0, 0},
        '{OP_PIXEL,      0,   0,   0,   0, 'hFFFF, 1, 0,     0, 0},
        '{OP_SET_WINDOW, 238, 10,  4,   2, 'h0000, 1, 0,     0, 0},
        '{OP_PIXEL,      0,   0,   0,   0, 'hAAAA, 0, 0,     0, 0},
        '{OP_PIXEL,      0,   0,   0,   0, 'h5555, 0, 0,     0, 0},
        '{OP_PIXEL,      0,   0,   0,   0, 'hFFFF, 0, 0,     0, 0},
        '{OP_SET_WINDOW, 0,   0,   320, 320, 'h0000, 1, 0,   0, 0},
        '{OP_PIXEL,      0,   0,   0,   0, 'h8410, 0, 0,     0, 0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic int eff_side(logic [PANEL_W-1:0] v);
        return (int'(v) > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    function automatic t_wr_item next_frame_write(t_cmd c);
        t_wr_item w;
        int       pw;
        int       ph;
        int       addr;
        logic     hit;
        w = '0;
        if (c.opcode == OP_SET_WINDOW) begin
            pen_col    = {1'b0, c.win_x};
            pen_row    = {1'b0, c.win_y};
            box_left   = pen_col;
            box_top    = pen_row;
            box_empty  = (c.win_w == '0) || (c.win_h == '0);
            box_right  = box_empty ? box_left : box_left + {1'b0, c.win_w} - 10'd1;
            box_bottom = box_empty ? box_top : box_top + {1'b0, c.win_h} - 10'd1;
            return w;
        end
        pw  = eff_side(cfg_width);
        ph  = eff_side(cfg_height);
        hit = !box_empty && pen_col >= box_left && pen_col <= box_right
              && pen_row >= box_top && pen_row <= box_bottom
              && int'(pen_col) < pw && int'(pen_row) < ph;
        if (hit) begin
            addr            = int'(pen_row) * pw + int'(pen_col);
            w.write_valid   = 1'b1;
            w.write_address = addr[ADDR_W-1:0];
            w.write_rgb     = ({8'h00, c.pixel_color & 16'hF800} << 8)
                            | ({8'h00, c.pixel_color & 16'h07E0} << 5)
                            | ({8'h00, c.pixel_color & 16'h001F} << 3);
            if (pen_col == box_right) begin
                pen_col = box_left;
                pen_row = (pen_row == box_bottom) ? box_top : pen_row + 10'd1;
            end else begin
                pen_col = pen_col + 10'd1;
            end
        end
        return w;
    endfunction

    function automatic void check_field(string label, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, label, want, got);
        end
    endfunction

    function automatic t_cmd rand_cmd(t_opcode op);
        t_cmd c;
        c.opcode      = op;
        c.win_x       = 9'($urandom);
        c.win_y       = 9'($urandom);
        c.win_w       = 9'($urandom);
        c.win_h       = 9'($urandom);
        c.pixel_color = 16'($urandom);
        return c;
    endfunction

    task automatic apb_xfer(input logic wr, input t_reg_idx idx,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(negedge i_clk); while (!pready);
        rdata = prdata;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(t_reg_idx idx, logic [PANEL_W-1:0] want);
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b0, idx, '0, rd);
        check_field(idx == REG_PANEL_WIDTH ? "panel_width" : "panel_height",
                    32'(want), rd);
    endtask

    task automatic set_panel(int width, int height);
        logic [APB_DATA_W-1:0] rd;
        apb_xfer(1'b1, REG_PANEL_WIDTH, {23'($urandom), 9'(width)}, rd);
        cfg_width = 9'(width);
        apb_xfer(1'b1, REG_PANEL_HEIGHT, {23'($urandom), 9'(height)}, rd);
        cfg_height = 9'(height);
        check_reg(REG_PANEL_WIDTH, cfg_width);
        check_reg(REG_PANEL_HEIGHT, cfg_height);
    endtask

    task automatic wait_idle();
        pix_if.valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_cmd(t_cmd c, bit typed, t_wr_item want);
        int gap;
        if ($urandom_range(0, 15) == 0) feed_burst = !feed_burst;
        gap = feed_burst ? 0 : int'($urandom_range(0, 3));
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.opcode      <= c.opcode;
        pix_if.win_x       <= c.win_x;
        pix_if.win_y       <= c.win_y;
        pix_if.win_w       <= c.win_w;
        pix_if.win_h       <= c.win_h;
        pix_if.pixel_color <= c.pixel_color;
        do @(negedge i_clk); while (!pix_if.ready);
        want = typed ? want : next_frame_write(c);
        if (typed) void'(next_frame_write(c));
        pending_writes.push_back(want);
        @(posedge i_clk);
    endtask

    task automatic run_random(int n_items);
        int   sent;
        int   pw;
        int   ph;
        int   w;
        int   h;
        int   x;
        int   y;
        int   npix;
        t_cmd c;
        sent = 0;
        pw   = eff_side(cfg_width);
        ph   = eff_side(cfg_height);
        if (pw == 0) pw = 1;
        if (ph == 0) ph = 1;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 80) begin
                w = int'($urandom_range(1, 8));
                h = int'($urandom_range(1, 4));
                x = ($urandom_range(0, 3) == 0) ? pw - w + int'($urandom_range(0, w))
                                                : int'($urandom_range(0, pw - 1));
                y = ($urandom_range(0, 3) == 0) ? ph - h + int'($urandom_range(0, h))
                                                : int'($urandom_range(0, ph - 1));
                if (x < 0) x = 0;
                if (y < 0) y = 0;
                c       = rand_cmd(OP_SET_WINDOW);
                c.win_x = 9'(x);
                c.win_y = 9'(y);
                c.win_w = 9'(w);
                c.win_h = 9'(h);
                send_cmd(c, 1'b0, '0);
                npix = int'($urandom_range(1, 2 * w * h));
                repeat (npix) send_cmd(rand_cmd(OP_PIXEL), 1'b0, '0);
                sent += npix + 1;
            end else begin
                send_cmd(rand_cmd(t_opcode'($urandom_range(0, 1))), 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin
        int gap;
        t_wr_item want;
        wr_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 15) == 0) drain_burst = !drain_burst;
            gap = drain_burst ? 0 : int'($urandom_range(0, 3));
            if (gap > 0) begin
                wr_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            wr_if.ready <= 1'b1;
            do @(negedge i_clk); while (wr_if.valid !== 1'b1);
            if (pending_writes.size() == 0) begin
                error_count++;
                $display("%0t: unexpected write item: expected none, got %0h %0h %0h",
                         $time, wr_if.write_valid, wr_if.write_address, wr_if.write_rgb);
            end else begin
                want = pending_writes.pop_front();
                check_field("write_valid", 32'(want.write_valid), 32'(wr_if.write_valid));
                check_field("write_address", 32'(want.write_address),
                            32'(wr_if.write_address));
                check_field("write_rgb", 32'(want.write_rgb), 32'(wr_if.write_rgb));
            end
            @(posedge i_clk);
        end
    end

    initial begin
        t_cmd     c;
        t_wr_item want;
        int       p;
        pix_if.valid       <= 1'b0;
        pix_if.opcode      <= 1'b0;
        pix_if.win_x       <= '0;
        pix_if.win_y       <= '0;
        pix_if.win_w       <= '0;
        pix_if.win_h       <= '0;
        pix_if.pixel_color <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        i_rst_n            <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_reg(REG_PANEL_WIDTH, 9'd240);
        check_reg(REG_PANEL_HEIGHT, 9'd320);

        foreach (probe_rows[i]) begin
            c.opcode           = probe_rows[i].op;
            c.win_x            = 9'(probe_rows[i].x);
            c.win_y            = 9'(probe_rows[i].y);
            c.win_w            = 9'(probe_rows[i].w);
            c.win_h            = 9'(probe_rows[i].h);
            c.pixel_color      = 16'(probe_rows[i].color);
            want.write_valid   = probe_rows[i].valid[0];
            want.write_address = 17'(probe_rows[i].addr);
            want.write_rgb     = 24'(probe_rows[i].rgb);
            send_cmd(c, probe_rows[i].typed, want);
        end

        for (p = 0; p < N_PHASES; p++) begin
            wait_idle();
            if (p < N_PLANNED) begin
                set_panel(PLAN_W[p], PLAN_H[p]);
            end else begin
                set_panel(($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 511))
                                                      : int'($urandom_range(1, 320)),
                          ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 511))
                                                      : int'($urandom_range(1, 320)));
            end
            run_random(PHASE_ITEMS);
        end

        wait_idle();
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ----- lcd_window_pixel_writer_unit.f -----
+incdir+sv
sv/lcdwpw_pkg.sv
sv/lcdwpw_in_if.sv
sv/lcdwpw_out_if.sv
sv/lcdwpw_step.sv
sv/lcd_window_pixel_writer_unit.sv
dv/testbench.sv
